@@ src/circular_fifo_queue_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the circular FIFO queue core
// Each macro checks a property on the rising clock edge and is switched off
// while reset is low. They expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/cfq_pkg.sv @@
// ---------------------------------------------------------------------------
// cfq_pkg
// Widths, operation and status codes and the controller state type of the
// circular FIFO queue core.
// ---------------------------------------------------------------------------
package cfq_pkg;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int OCC_W      = 4;
    localparam int OUT_DATA_W = 104;

    // Operation codes carried on the input tuser
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;

    // Status codes carried on the output tuser
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NEVER_USED = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } t_state;

endpackage

@@ src/cfq_slot_ram.sv @@
// ---------------------------------------------------------------------------
// cfq_slot_ram
// Slot store of the queue: one write port and one read port, read data
// registered.
// ---------------------------------------------------------------------------
module cfq_slot_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [cfq_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [cfq_pkg::WORD_W-1:0] o_rd_data
);
    import cfq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    // Write one slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one slot, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/circular_fifo_queue_core.sv @@
// The result beat is registered. A push, query or refused pop goes from idle
// straight to send; a pop that leaves words behind passes through fetch, as
// the slot RAM read data is registered (head refetch). A new input beat is
// taken only in idle, once the previous result beat has been sent.
// Reset (synchronous, active low) empties the queue and clears the used flag.
// ---------------------------------------------------------------------------
// circular_fifo_queue_core
// Ring-buffer FIFO of signed words. Each input beat pushes, pops or queries;
// each gives one result beat with status, popped word, head and tail words,
// occupancy and full/empty flags. The oldest and newest words are cached in
// registers; the slot RAM is read only to refill the head after a pop.
// ---------------------------------------------------------------------------
`include "circular_fifo_queue_core_macros.svh"

module circular_fifo_queue_core #(
    parameter int DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [cfq_pkg::WORD_W-1:0]     i_s_tdata,  // [31:0] push_value
    input  logic [cfq_pkg::MODE_W-1:0]     i_s_tuser,  // [1:0] mode
    // Output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] popped_value, [63:32] head_value, [95:64] tail_value,
    // [99:96] occupancy, [100] is_full, [101] is_empty, [103:102] zero
    output logic [cfq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [cfq_pkg::STAT_W-1:0]     o_m_tuser   // [1:0] status
);
    import cfq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Control state
    t_state            r_state,    n_state;
    logic [AW-1:0]     r_head_idx, n_head_idx;
    logic [AW-1:0]     r_tail_idx, n_tail_idx;
    logic [CW-1:0]     r_count,    n_count;
    logic              r_ever,     n_ever;
    // Cached end words
    logic [WORD_W-1:0] r_head_word, n_head_word;
    logic [WORD_W-1:0] r_tail_word, n_tail_word;
    // Result register
    logic [STAT_W-1:0] r_status,   n_status;
    logic [WORD_W-1:0] r_popped,   n_popped;
    logic [WORD_W-1:0] r_out_head, n_out_head;
    logic [WORD_W-1:0] r_out_tail, n_out_tail;
    logic [OCC_W-1:0]  r_out_occ,  n_out_occ;
    logic              r_full,     n_full;
    logic              r_empty,    n_empty;

    // Slot RAM access
    logic              w_wr_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_rd_en;
    logic [WORD_W-1:0] w_rd_data;

    logic              w_accept;
    logic [AW-1:0]     w_head_inc;
    logic [AW-1:0]     w_tail_inc;

    assign w_accept   = (r_state == ST_IDLE) && i_s_tvalid;
    assign w_head_inc = (r_head_idx == AW'(DEPTH - 1)) ? '0 : r_head_idx + 1'b1;
    assign w_tail_inc = (r_tail_idx == AW'(DEPTH - 1)) ? '0 : r_tail_idx + 1'b1;
    assign w_rd_addr  = w_head_inc;

    cfq_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail_idx),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next state: apply the operation, build the result, refetch the head
    always_comb begin
        n_state     = r_state;
        n_head_idx  = r_head_idx;
        n_tail_idx  = r_tail_idx;
        n_count     = r_count;
        n_ever      = r_ever;
        n_head_word = r_head_word;
        n_tail_word = r_tail_word;
        n_status    = r_status;
        n_popped    = r_popped;
        n_out_head  = r_out_head;
        n_out_tail  = r_out_tail;
        n_out_occ   = r_out_occ;
        n_full      = r_full;
        n_empty     = r_empty;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_status = STAT_OK;
                    n_popped = '0;
                    n_state  = ST_SEND;
                    if (i_s_tuser == MODE_PUSH) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = STAT_OVERFLOW;
                        end else begin
                            w_wr_en     = 1'b1;
                            n_tail_idx  = w_tail_inc;
                            n_count     = r_count + 1'b1;
                            n_ever      = 1'b1;
                            n_tail_word = i_s_tdata;
                            if (r_count == '0) begin
                                n_head_word = i_s_tdata;
                            end
                        end
                    end else if (i_s_tuser == MODE_POP) begin
                        if (r_count == '0) begin
                            n_status = r_ever ? STAT_UNDERFLOW : STAT_NEVER_USED;
                        end else begin
                            n_popped   = r_head_word;
                            n_head_idx = w_head_inc;
                            n_count    = r_count - 1'b1;
                            // Words remain: fetch the new oldest word
                            if (r_count != CW'(1)) begin
                                w_rd_en = 1'b1;
                                n_state = ST_FETCH;
                            end
                        end
                    end
                    n_out_head = (n_count != '0) ? n_head_word : '0;
                    n_out_tail = (n_count != '0) ? n_tail_word : '0;
                    n_out_occ  = OCC_W'(n_count);
                    n_full     = (n_count == CW'(DEPTH));
                    n_empty    = (n_count == '0);
                end
            end
            ST_FETCH: begin
                // Take the refetched head into the cache and the result
                n_head_word = w_rd_data;
                n_out_head  = w_rd_data;
                n_state     = ST_SEND;
            end
            ST_SEND: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head_idx <= '0;
            r_tail_idx <= '0;
            r_count    <= '0;
            r_ever     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head_idx <= n_head_idx;
            r_tail_idx <= n_tail_idx;
            r_count    <= n_count;
            r_ever     <= n_ever;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_head_word <= n_head_word;
        r_tail_word <= n_tail_word;
        r_status    <= n_status;
        r_popped    <= n_popped;
        r_out_head  <= n_out_head;
        r_out_tail  <= n_out_tail;
        r_out_occ   <= n_out_occ;
        r_full      <= n_full;
        r_empty     <= n_empty;
    end

    // Drive the ports
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_SEND);
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {2'b00, r_empty, r_full, r_out_occ,
                         r_out_tail, r_out_head, r_popped};

    // Checks
    `CFQ_ASSERT_NEXT(a_fetch_to_send, i_clk, i_rst_n, r_state == ST_FETCH, r_state == ST_SEND)
    `CFQ_ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `CFQ_ASSERT_IMPLIES(a_flags_excl, i_clk, i_rst_n, o_m_tvalid, !(r_full && r_empty))
    `CFQ_ASSERT_IMPLIES(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_head_idx == r_tail_idx)
    `CFQ_ASSERT_IMPLIES(a_used_flag, i_clk, i_rst_n, r_count != '0, r_ever)

endmodule
